// ===== sv/hri_pkg.sv =====
// Shared widths, state codes and the cell control bundle of the radical inverse block.
package hri_pkg;

   localparam int BASE_BITS          = 8;
   localparam int INDEX_PORT_BITS    = 32;
   localparam int FRACTION_PORT_BITS = 32;

   typedef logic [BASE_BITS-1:0]          base_type;
   typedef logic [INDEX_PORT_BITS-1:0]    index_type;
   typedef logic [FRACTION_PORT_BITS-1:0] fraction_type;

   // one-hot sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SPLIT  = 4'b0010,
      ST_MIRROR = 4'b0100,
      ST_DONE   = 4'b1000
   } hri_state_type;

   // control shared by every divider cell of the row
   typedef struct packed {
      logic     clear;   // zero the remainder before a new index
      logic     flush;   // drop in-flight valid tokens at a phase change
      base_type base;    // divisor
   } hri_cell_ctl_type;

endpackage

// ===== sv/hri_channels.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface hri_req_if import hri_pkg::*; ();
   logic      valid;
   logic      ready;
   base_type  base;
   index_type index;

   modport source (output valid, output base, output index, input ready);
   modport sink   (input valid, input base, input index, output ready);
endinterface

interface hri_rsp_if import hri_pkg::*; ();
   logic         valid;
   logic         ready;
   fraction_type fraction;
   logic         bad_base;

   modport source (output valid, output fraction, output bad_base, input ready);
   modport sink   (input valid, input fraction, input bad_base, output ready);
endinterface

// ===== sv/hri_cell.sv =====
// Bit-serial divider cell: one dividend bit in, one quotient bit out, remainder kept.
module hri_cell import hri_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  hri_cell_ctl_type ctl,
   input  logic             in_bit,
   input  logic             in_valid,
   output logic             out_bit,
   output logic             out_valid
);

   logic [BASE_BITS-1:0] rem_ff, rem_in;
   logic                 q_ff;
   logic                 v_ff, v_in;
   logic [BASE_BITS:0]   trial;
   logic [BASE_BITS:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, in_bit};
   assign diff  = trial - {1'b0, ctl.base};
   assign fits  = (trial >= {1'b0, ctl.base});

   always_comb begin
      priority if (ctl.clear) begin
         rem_in = '0;
      end else if (in_valid) begin
         rem_in = fits ? diff[BASE_BITS-1:0] : trial[BASE_BITS-1:0];
      end else begin
         rem_in = rem_ff;
      end
      v_in = in_valid & ~ctl.flush & ~ctl.clear;
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (in_valid) begin
         q_ff <= fits;
      end
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign out_bit   = q_ff;
   assign out_valid = v_ff;

endmodule

// ===== sv/halton_radical_inverse.sv =====
// Top level of the Halton radical inverse block: sequencer, divider cell row, response register.
//
//   channel | dir | transfer contents               | when
//   --------+-----+---------------------------------+-----------------------------
//   req_ch  | in  | base (8b), index (32b)          | req_ch.valid & req_ch.ready
//   rsp_ch  | out | fraction (Q0.32), bad_base (1b) | rsp_ch.valid & rsp_ch.ready
//
// A new request is taken only once the last item has left the sequencer; each item
// makes a bit-serial walk through the cell row: the index streams forward through
// INDEX_BITS cells, then the fraction streams back. A base below two skips the row.
// Reset (synchronous) returns the sequencer to idle and empties the response register.
// A stalled response holds in its register while the next item is already taken in;
// the sequencer waits in its final state only if that register is still full.
//
// Method: in the split phase cell k divides the quotient stream of cell k-1 by the base,
// so once the index has passed, cell k holds base digit k as its remainder. In the
// mirror phase the stream turns round: cell j starts from remainder d_j and divides the
// quotient stream of cell j+1, giving acc_j = floor((d_j*2^F + acc_(j+1)) / b) MSB first.
// Cell 0 delivers the fraction. Leading zero digits leave the result untouched.
module halton_radical_inverse import hri_pkg::*; #(
   parameter int INDEX_BITS    = 32,
   parameter int FRACTION_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   hri_req_if.sink    req_ch,
   hri_rsp_if.source  rsp_ch
);

   localparam int CntBits = $clog2(2 * INDEX_BITS + FRACTION_BITS);

   hri_state_type state_ff, state_in;
   logic [CntBits-1:0]       cnt_ff, cnt_in;
   base_type                 base_ff, base_in;
   logic [INDEX_BITS-1:0]    idx_ff, idx_in;
   logic [FRACTION_BITS-1:0] acc_ff, acc_in;
   logic                     bad_ff, bad_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   fraction_type             rsp_frac_ff, rsp_frac_in;
   logic                     rsp_bad_ff, rsp_bad_in;

   logic                     req_take;
   logic                     rsp_free;
   hri_cell_ctl_type         cell_ctl;

   logic [INDEX_BITS-1:0]    cell_in_bit;
   logic [INDEX_BITS-1:0]    cell_in_valid;
   logic [INDEX_BITS-1:0]    cell_q;
   logic [INDEX_BITS-1:0]    cell_v;

   logic [INDEX_BITS+INDEX_PORT_BITS-1:0]       idx_wide;
   logic [FRACTION_BITS+FRACTION_PORT_BITS-1:0] frac_wide;

   logic split_feed;   // index bits still entering cell 0
   logic mirror_feed;  // zero bits still entering the top cell
   logic split_last;
   logic mirror_last;

   assign idx_wide  = {{INDEX_BITS{1'b0}}, req_ch.index};
   assign frac_wide = {{FRACTION_PORT_BITS{1'b0}}, acc_ff};

   assign req_take = (state_ff == ST_IDLE) & req_ch.valid;
   assign rsp_free = ~rsp_valid_ff | rsp_ch.ready;

   assign split_feed  = (cnt_ff < CntBits'(INDEX_BITS));
   assign mirror_feed = (cnt_ff < CntBits'(FRACTION_BITS));
   assign split_last  = (cnt_ff == CntBits'(2 * INDEX_BITS - 2));
   assign mirror_last = (cnt_ff == CntBits'(INDEX_BITS + FRACTION_BITS - 1));

   // Row control: clear remainders on a new index, drop tokens when direction turns.
   always_comb begin
      cell_ctl.base  = base_ff;
      cell_ctl.clear = req_take;
      cell_ctl.flush = (state_ff == ST_SPLIT) & split_last;
   end

   // Route each cell's input: from below while splitting, from above while mirroring.
   for (genvar k = 0; k < INDEX_BITS; k++) begin : g_row
      if (k == 0) begin : g_first
         always_comb begin
            unique case (state_ff)
               ST_SPLIT: begin
                  cell_in_bit[k]   = idx_ff[INDEX_BITS-1];
                  cell_in_valid[k] = split_feed;
               end
               ST_MIRROR: begin
                  cell_in_bit[k]   = cell_q[k+1];
                  cell_in_valid[k] = cell_v[k+1];
               end
               default: begin
                  cell_in_bit[k]   = 1'b0;
                  cell_in_valid[k] = 1'b0;
               end
            endcase
         end
      end else if (k == INDEX_BITS - 1) begin : g_last
         always_comb begin
            unique case (state_ff)
               ST_SPLIT: begin
                  cell_in_bit[k]   = cell_q[k-1];
                  cell_in_valid[k] = cell_v[k-1];
               end
               ST_MIRROR: begin
                  cell_in_bit[k]   = 1'b0;
                  cell_in_valid[k] = mirror_feed;
               end
               default: begin
                  cell_in_bit[k]   = 1'b0;
                  cell_in_valid[k] = 1'b0;
               end
            endcase
         end
      end else begin : g_mid
         always_comb begin
            unique case (state_ff)
               ST_SPLIT: begin
                  cell_in_bit[k]   = cell_q[k-1];
                  cell_in_valid[k] = cell_v[k-1];
               end
               ST_MIRROR: begin
                  cell_in_bit[k]   = cell_q[k+1];
                  cell_in_valid[k] = cell_v[k+1];
               end
               default: begin
                  cell_in_bit[k]   = 1'b0;
                  cell_in_valid[k] = 1'b0;
               end
            endcase
         end
      end

      hri_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .in_bit    (cell_in_bit[k]),
         .in_valid  (cell_in_valid[k]),
         .out_bit   (cell_q[k]),
         .out_valid (cell_v[k])
      );
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_frac_in  = rsp_frac_ff;
      rsp_bad_in   = rsp_bad_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               base_in = req_ch.base;
               idx_in  = idx_wide[INDEX_BITS-1:0];
               acc_in  = '0;
               cnt_in  = '0;
               if (req_ch.base < base_type'(2)) begin
                  bad_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  bad_in   = 1'b0;
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            // advance the index MSB first into cell 0
            idx_in = {idx_ff[INDEX_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + CntBits'(1);
            if (split_last) begin
               cnt_in   = '0;
               state_in = ST_MIRROR;
            end
         end
         ST_MIRROR: begin
            if (cell_v[0]) begin
               acc_in = {acc_ff[FRACTION_BITS-2:0], cell_q[0]};
            end
            cnt_in = cnt_ff + CntBits'(1);
            if (mirror_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the response register can take the result
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_frac_in  = frac_wide[FRACTION_PORT_BITS-1:0];
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      bad_ff      <= bad_in;
      rsp_frac_ff <= rsp_frac_in;
      rsp_bad_ff  <= rsp_bad_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.fraction = rsp_frac_ff;
   assign rsp_ch.bad_base = rsp_bad_ff;

endmodule

// ===== verif/radical_inverse_checker.sv =====
// Checker that watches both channels, predicts each radical inverse and compares the results.
`timescale 1ns / 100ps

module radical_inverse_checker import hri_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  base_type     req_base,
   input  index_type    req_index,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  fraction_type rsp_fraction,
   input  logic         rsp_bad_base,
   output int           fail_count,
   output int           result_count,
   output int           pending_count
);

   typedef struct packed {
      fraction_type fraction;
      logic         bad_base;
   } mirrored_type;

   mirrored_type expected_fractions[$];
   int           fail_total   = 0;
   int           result_total = 0;

   assign fail_count    = fail_total;
   assign result_count  = result_total;
   assign pending_count = expected_fractions.size();

   // Split the index into base-b digits, then fold them back from the top digit down.
   function automatic mirrored_type mirror_digits(base_type b, index_type idx);
      logic [7:0]  digit_list [0:31];
      logic [63:0] rest;
      logic [63:0] acc;
      logic [63:0] wide_base;
      int          count;
      int          k;
      mirrored_type r;
      r = '0;
      if (b < 2) begin
         r.bad_base = 1'b1;
         return r;
      end
      wide_base = {56'd0, b};
      rest      = {32'd0, idx};
      acc       = '0;
      count     = 0;
      while (rest != 0) begin
         digit_list[count] = 8'(rest % wide_base);
         rest              = rest / wide_base;
         count++;
      end
      for (k = count - 1; k >= 0; k--)
         acc = (({56'd0, digit_list[k]} << FRACTION_PORT_BITS) + acc) / wide_base;
      r.fraction = acc[FRACTION_PORT_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      mirrored_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_fractions.push_back(mirror_digits(req_base, req_index));
         if (rsp_valid && rsp_ready) begin
            result_total <= result_total + 1;
            if (expected_fractions.size() == 0) begin
               if (fail_total < 10)
                  $display("%0t: unexpected result fraction %h bad_base %b",
                           $realtime, rsp_fraction, rsp_bad_base);
               fail_total <= fail_total + 1;
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_fraction !== want.fraction || rsp_bad_base !== want.bad_base) begin
                  if (fail_total < 10)
                     $display("%0t: mismatch fraction exp %h got %h, bad_base exp %b got %b",
                              $realtime, want.fraction, rsp_fraction, want.bad_base,
                              rsp_bad_base);
                  fail_total <= fail_total + 1;
               end
            end
         end
      end
   end

endmodule

// ===== verif/halton_radical_inverse_test.sv =====
// Top of the radical inverse testbench: clock, reset, request stimulus, result sink and verdict.
`timescale 1ns / 100ps

module halton_radical_inverse_test;
   import hri_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hri_req_if req_ch ();
   hri_rsp_if rsp_ch ();

   int fail_count;
   int result_count;
   int pending_count;
   int sent_count = 0;

   // Burst flags switch off the random gaps for a stretch on each side.
   bit send_burst = 1'b0;
   bit take_burst = 1'b0;

   halton_radical_inverse #(
      .INDEX_BITS    (32),
      .FRACTION_BITS (32)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   radical_inverse_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_base      (req_ch.base),
      .req_index     (req_ch.index),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_fraction  (rsp_ch.fraction),
      .rsp_bad_base  (rsp_ch.bad_base),
      .fail_count    (fail_count),
      .result_count  (result_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop: far beyond the slowest clean run.
   initial begin
      #8_000_000;
      $display("halton_radical_inverse_test: done, errors");
      $finish;
   end

   function automatic int draw_gap(bit burst);
      return burst ? 0 : $urandom_range(13, 0);
   endfunction

   // Offer one request after a random gap and hold it until the transfer happens.
   // Keep valid high across back-to-back items so it is never dropped and raised in one step.
   task automatic send_query(base_type b, index_type idx);
      int gap;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         req_ch.base  <= base_type'($urandom);
         req_ch.index <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.base  <= b;
      req_ch.index <= idx;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sent_count++;
   endtask

   // Hold off the sender until every outstanding result has been taken.
   task automatic drain_results();
      wait (result_count == sent_count);
      @(posedge clock);
   endtask

   // Result sink: draw a stall per item, then hold ready until a transfer completes.
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap(take_burst);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         // Flip into or out of a stall-free stretch now and then.
         if ($urandom_range(29, 0) == 0)
            take_burst = !take_burst;
      end
   end

   initial begin
      base_type    b;
      index_type   idx;
      logic [63:0] power;
      int          steps;
      int          pick;

      req_ch.valid <= 1'b0;
      req_ch.base  <= '0;
      req_ch.index <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: bad bases, index zero, field extremes, exact powers of the base.
      send_query(8'd0,   32'h0000_0000);
      send_query(8'd1,   32'hFFFF_FFFF);
      send_query(8'd0,   32'hA5A5_A5A5);
      send_query(8'd1,   32'h0000_0001);
      send_query(8'd2,   32'h0000_0000);
      send_query(8'd2,   32'h0000_0001);
      send_query(8'd2,   32'hFFFF_FFFF);
      send_query(8'd2,   32'h8000_0000);
      send_query(8'd2,   32'h5555_5555);
      send_query(8'd3,   32'hFFFF_FFFF);
      send_query(8'd3,   32'd3486784401);
      send_query(8'd5,   32'd1220703125);
      send_query(8'd7,   32'd5555555);
      send_query(8'd10,  32'd1234567890);
      send_query(8'd16,  32'h0123_4567);
      send_query(8'd128, 32'h7FFF_FFFF);
      send_query(8'd200, 32'hAAAA_AAAA);
      send_query(8'd254, 32'hFFFF_FFFF);
      send_query(8'd255, 32'h0000_0000);
      send_query(8'd255, 32'h0000_0001);
      send_query(8'd255, 32'h0000_00FE);
      send_query(8'd255, 32'd65025);
      send_query(8'd255, 32'hFFFF_FFFF);

      // Let the pipeline run dry once before the random part.
      drain_results();

      for (int n = 0; n < 600; n++) begin
         if (n == 300)
            drain_results();
         if (n % 40 == 0)
            send_burst = ($urandom_range(3, 0) == 0);

         pick = $urandom_range(99, 0);
         if (pick < 5)
            b = base_type'($urandom_range(1, 0));
         else if (pick < 15) begin
            case ($urandom_range(3, 0))
               0:       b = 8'd2;
               1:       b = 8'd3;
               2:       b = 8'd254;
               default: b = 8'd255;
            endcase
         end else
            b = base_type'($urandom_range(255, 2));

         case ($urandom_range(9, 0))
            0, 1, 2, 3: idx = $urandom;
            4, 5:       idx = $urandom_range(255, 0);
            6: begin
               // Near an exact power of the base: a single leading one digit or all top digits.
               power = 64'd1;
               steps = $urandom_range(31, 0);
               repeat (steps)
                  if (b > 1 && power * b <= 64'hFFFF_FFFF)
                     power = power * b;
               idx = 32'(power - $urandom_range(1, 0));
            end
            7:          idx = 32'hFFFF_FFFF ^ (32'd1 << $urandom_range(31, 0));
            8:          idx = $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default:    idx = 32'd1 << $urandom_range(31, 0);
         endcase
         send_query(b, idx);
      end
      req_ch.valid <= 1'b0;

      // Wait for the last results, then give the block time to show any stray transfer.
      wait (result_count == sent_count);
      repeat (150) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("halton_radical_inverse_test: done, clean");
      else
         $display("halton_radical_inverse_test: done, errors");
      $finish;
   end

endmodule
